@@ src/vcqt_pkg.sv @@
// View-change quorum tracker: shared types, codes and reset values.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package vcqt_pkg;

   typedef enum logic [1:0] {
      OP_COLLECT = 2'd0,
      OP_VERIFY  = 2'd1,
      OP_RESET   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      STS_OK            = 4'd0,
      STS_BAD_SENDER    = 4'd1,
      STS_SHORT         = 4'd2,
      STS_STALE         = 4'd3,
      STS_DUPLICATE     = 4'd4,
      STS_STORE_FAIL    = 4'd5,
      STS_VIEW_MISMATCH = 4'd6,
      STS_MIN_ABOVE_MAX = 4'd7,
      STS_NO_QUORUM     = 4'd8,
      STS_MIN_LOW       = 4'd9,
      STS_MAX_HIGH      = 4'd10,
      STS_PROOFS        = 4'd11
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   localparam logic [1:0] CSR_SCAN_LIMIT = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD  = 2'd1;
   localparam logic [1:0] CSR_WIN_SPAN   = 2'd2;

   localparam logic [4:0]  SCAN_LIMIT_RESET = 5'd4;
   localparam logic [4:0]  THRESHOLD_RESET  = 5'd3;
   localparam logic [15:0] WIN_SPAN_RESET   = 16'd256;

   typedef struct packed {
      op_type      operation;
      logic [5:0]  sender;
      logic [62:0] view;
      logic [47:0] ckpt_seq;
      logic [47:0] proposed_min;
      logic [48:0] proposed_max;
      logic        length_ok;
      logic        store_ok;
      logic        proofs_ok;
   } req_type;

   typedef struct packed {
      logic        accepted;
      status_type  status;
      logic [62:0] current_view;
      logic        quorum;
      logic [47:0] bound_lo;
      logic [48:0] bound_hi;
      logic [4:0]  vote_count;
   } rsp_type;

   // Table command broadcast to every cell.
   typedef struct packed {
      logic        clear;
      logic        write;
      logic [5:0]  wr_idx;
      logic [47:0] wr_value;
   } cell_cmd_type;

   // Partial bounds handed from cell to cell.
   typedef struct packed {
      logic        found;
      logic [47:0] mn;
      logic [48:0] mx;
   } scan_type;

endpackage

@@ src/view_change_quorum_tracker.sv @@
// Top level of the view-change quorum tracker: sequencer plus a row of replica cells.
// Depends on vcqt_pkg, vcqt_cell and vcqt_ctrl.
`timescale 1ns / 1ps

// Channel | Direction | Ports                          | Beat
// --------+-----------+--------------------------------+---------------------------------
// request | in        | req_valid, req_ready, req_data | one vote, proposal or view reset
// result  | out       | rsp_valid, rsp_ready, rsp_data | verdict, view, bounds and count
// config  | in        | csr_we, csr_index, csr_wdata   | one register write, no wait
//
// Each item runs as follows: the accept edge updates the table, the bounds wave then crosses
// the cell row through each cell's scan register, and the verdict settles into the result register.
// Synchronous reset clears the marks, vote count and target view and reloads the
// config defaults; no clearing pass follows. A result waits in its register while the
// next request beat is taken; the verdict cycle holds while that register stays full.

module view_change_quorum_tracker #(
   parameter int MAX_REPLICAS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vcqt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vcqt_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import vcqt_pkg::*;

   // Bounds travel from the head (slot 0) to the tail one cell per cycle.
   scan_type                chain [MAX_REPLICAS+1];
   logic [MAX_REPLICAS-1:0] marks;
   cell_cmd_type            cmd;
   logic [4:0]              scan_limit;
   logic [15:0]             win_span;
   scan_type                scan_head;

   vcqt_ctrl #(
      .MAX_REPLICAS(MAX_REPLICAS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .marks       (marks),
      .scan_tail   (chain[MAX_REPLICAS]),
      .scan_head   (scan_head),
      .cmd         (cmd),
      .scan_limit  (scan_limit),
      .win_span    (win_span)
   );

   assign chain[0] = scan_head;

   // One cell per replica slot; each holds its mark and last stable value.
   for (genvar i = 0; i < MAX_REPLICAS; i++) begin : g_cell
      vcqt_cell #(
         .INDEX(i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .scan_limit  (scan_limit),
         .win_span    (win_span),
         .scan_in     (chain[i]),
         .scan_out    (chain[i+1]),
         .mark        (marks[i])
      );
   end

endmodule

@@ src/vcqt_cell.sv @@
// One replica slot: received mark, last stable value and one scan stage.
// Depends on vcqt_pkg.
`timescale 1ns / 1ps

module vcqt_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vcqt_pkg::cell_cmd_type cmd,
   input  logic [4:0]            scan_limit,
   input  logic [15:0]           win_span,
   input  vcqt_pkg::scan_type    scan_in,
   output vcqt_pkg::scan_type    scan_out,
   output logic                  mark
);
   import vcqt_pkg::*;

   localparam logic [6:0] IDX = 7'(INDEX);

   logic        mark_ff;
   logic [47:0] stable_ff;
   scan_type    scan_ff;
   scan_type    scan_in_d;
   logic        hit;
   logic        take;
   logic [48:0] upper;

   assign hit   = cmd.write && (cmd.wr_idx == IDX[5:0]);
   assign take  = mark_ff && (IDX < {2'b00, scan_limit});
   assign upper = {1'b0, stable_ff} + {33'd0, win_span};

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= 1'b0;
      end else if (hit) begin
         mark_ff <= 1'b1;
      end else if (cmd.clear) begin
         mark_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         stable_ff <= cmd.wr_value;
      end
      scan_ff <= scan_in_d;
   end

   // Fold this slot into the bounds when it is marked and below the scan limit, and pass them on.
   always_comb begin
      scan_in_d = scan_in;
      if (take) begin
         scan_in_d.found = 1'b1;
         if (!scan_in.found) begin
            scan_in_d.mn = stable_ff;
            scan_in_d.mx = upper;
         end else begin
            if (stable_ff > scan_in.mn) begin
               scan_in_d.mn = stable_ff;
            end
            if (upper < scan_in.mx) begin
               scan_in_d.mx = upper;
            end
         end
      end
   end

   assign scan_out = scan_ff;
   assign mark     = mark_ff;

endmodule

@@ src/vcqt_ctrl.sv @@
// Sequencer: config registers, vote checks, view and count, verdict and result register.
// Depends on vcqt_pkg; drives the cell row built in the top level.
`timescale 1ns / 1ps

module vcqt_ctrl #(
   parameter int MAX_REPLICAS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  vcqt_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output vcqt_pkg::rsp_type      rsp_data,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wdata,
   input  logic [MAX_REPLICAS-1:0] marks,
   input  vcqt_pkg::scan_type     scan_tail,
   output vcqt_pkg::scan_type     scan_head,
   output vcqt_pkg::cell_cmd_type cmd,
   output logic [4:0]             scan_limit,
   output logic [15:0]            win_span
);
   import vcqt_pkg::*;

   localparam int         IDX_W  = $clog2(MAX_REPLICAS);
   localparam int         CNT_W  = $clog2(MAX_REPLICAS + 1);
   localparam logic [6:0] MAX_ID = 7'(MAX_REPLICAS);
   localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(MAX_REPLICAS - 1);

   state_type        state_ff, state_in;
   logic [4:0]       nr_ff;
   logic [4:0]       th_ff;
   logic [15:0]      win_ff;
   logic [62:0]      target_ff, target_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_cnt_ff, scan_cnt_in;
   status_type       status_ff, status_in;
   logic             acc_ff, acc_in;
   req_type          req_ff, req_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             in_range;
   logic             mark_hit;
   logic             newer;
   logic             quorum;
   logic [7:0]       count_ext;
   logic [47:0]      exp_min;
   logic [48:0]      exp_max;
   status_type       verify_status;
   status_type       final_status;
   logic             final_acc;

   assign in_range  = {1'b0, req_data.sender} < MAX_ID;
   assign mark_hit  = marks[req_data.sender[IDX_W-1:0]];
   assign newer     = req_data.view > target_ff;
   assign count_ext = 8'(count_ff);
   assign quorum    = count_ext >= {3'd0, th_ff};
   assign exp_min   = scan_tail.found ? scan_tail.mn : 48'd0;
   assign exp_max   = scan_tail.found ? scan_tail.mx : {33'd0, win_ff};

   // Verdict on a new-view proposal; the table does not move for it.
   always_comb begin
      priority if (!req_ff.length_ok) begin
         verify_status = STS_SHORT;
      end else if (req_ff.view != target_ff) begin
         verify_status = STS_VIEW_MISMATCH;
      end else if ({1'b0, req_ff.proposed_min} > req_ff.proposed_max) begin
         verify_status = STS_MIN_ABOVE_MAX;
      end else if (!quorum) begin
         verify_status = STS_NO_QUORUM;
      end else if (req_ff.proposed_min < exp_min) begin
         verify_status = STS_MIN_LOW;
      end else if (req_ff.proposed_max > exp_max) begin
         verify_status = STS_MAX_HIGH;
      end else if (!req_ff.proofs_ok) begin
         verify_status = STS_PROOFS;
      end else begin
         verify_status = STS_OK;
      end
   end

   assign final_status = (req_ff.operation == OP_VERIFY) ? verify_status : status_ff;
   assign final_acc    = (req_ff.operation == OP_VERIFY) ? (verify_status == STS_OK)
                                                        : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nr_ff  <= SCAN_LIMIT_RESET;
         th_ff  <= THRESHOLD_RESET;
         win_ff <= WIN_SPAN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCAN_LIMIT: nr_ff  <= csr_wdata[4:0];
            CSR_THRESHOLD:  th_ff  <= csr_wdata[4:0];
            CSR_WIN_SPAN:   win_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         target_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff <= scan_cnt_in;
      status_ff   <= status_in;
      acc_ff      <= acc_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      count_in     = count_ff;
      scan_cnt_in  = scan_cnt_ff;
      status_in    = status_ff;
      acc_in       = acc_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.wr_idx   = req_data.sender;
      cmd.wr_value = req_data.ckpt_seq;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in      = req_data;
               scan_cnt_in = '0;
               status_in   = STS_OK;
               acc_in      = 1'b0;
               state_in    = S_SCAN;
               unique case (req_data.operation)
                  OP_COLLECT: begin
                     priority if (!in_range) begin
                        status_in = STS_BAD_SENDER;
                     end else if (!req_data.length_ok) begin
                        status_in = STS_SHORT;
                     end else if (req_data.view < target_ff) begin
                        status_in = STS_STALE;
                     end else begin
                        // a higher view restarts the table, whatever follows
                        if (newer) begin
                           cmd.clear = 1'b1;
                           target_in = req_data.view;
                           count_in  = '0;
                        end
                        priority if (!newer && mark_hit) begin
                           status_in = STS_DUPLICATE;
                        end else if (!req_data.store_ok) begin
                           status_in = STS_STORE_FAIL;
                        end else begin
                           cmd.write = 1'b1;
                           acc_in    = 1'b1;
                           count_in  = (newer ? '0 : count_ff) + CNT_W'(1);
                        end
                     end
                  end
                  OP_RESET: begin
                     cmd.clear = 1'b1;
                     target_in = req_data.view;
                     count_in  = '0;
                  end
                  OP_VERIFY, OP_NONE: ;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_cnt_ff == SCAN_LAST) begin
               state_in = S_FINISH;
            end else begin
               scan_cnt_in = scan_cnt_ff + IDX_W'(1);
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.accepted     = final_acc;
               rsp_in.status       = final_status;
               rsp_in.current_view = target_ff;
               rsp_in.quorum       = quorum;
               rsp_in.bound_lo     = exp_min;
               rsp_in.bound_hi     = exp_max;
               rsp_in.vote_count   = (count_ext > 8'd31) ? 5'd31 : count_ext[4:0];
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign scan_head.found = 1'b0;
   assign scan_head.mn    = '0;
   assign scan_head.mx    = {33'd0, win_ff};

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign scan_limit = nr_ff;
   assign win_span   = win_ff;

endmodule
